// ----- rtl/gesp_pkg.sv -----
package gesp_pkg;

    localparam int ADC_W    = 16;
    localparam int PERIOD_W = 8;
    localparam int STEP_W   = 12;
    localparam int LEVEL_W  = 15;
    localparam int CRUSH_W  = 5;
    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0]  LEVEL_MAX       = 15'h7fff;
    localparam logic [PERIOD_W-1:0] RST_POLL_PERIOD = 8'd100;
    localparam logic [STEP_W-1:0]   RST_STEP        = 12'd100;
    localparam logic [LEVEL_W-1:0]  RST_CLIP_LEVEL  = 15'd6000;
    localparam logic [LEVEL_W-1:0]  RST_FUZZ_LEVEL  = 15'd8000;

    typedef enum logic [1:0] {
        EFF_CLEAN = 2'd0,
        EFF_DIST  = 2'd1,
        EFF_FUZZ  = 2'd2,
        EFF_CRUSH = 2'd3
    } t_effect;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLL_PERIOD  = 2'd0,
        CFG_THRESH_STEP  = 2'd1,
        CFG_DEFAULT_CLIP = 2'd2,
        CFG_DEFAULT_FUZZ = 2'd3
    } t_cfg_idx;

endpackage

// ----- rtl/gesp_in_if.sv -----
interface gesp_in_if;
    logic                          valid;
    logic                          ready;
    logic [gesp_pkg::ADC_W-1:0]    adc_word;
    logic                          select_button;
    logic                          up_button;
    logic                          down_button;

    modport source (
        output valid, adc_word, select_button, up_button, down_button,
        input  ready
    );
    modport sink (
        input  valid, adc_word, select_button, up_button, down_button,
        output ready
    );
endinterface

// ----- rtl/gesp_out_if.sv -----
interface gesp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pwm_high_byte;
    logic [7:0] pwm_low_byte;
    logic [1:0] active_effect;

    modport source (
        output valid, pwm_high_byte, pwm_low_byte, active_effect,
        input  ready
    );
    modport sink (
        input  valid, pwm_high_byte, pwm_low_byte, active_effect,
        output ready
    );
endinterface

// ----- rtl/guitar_effect_sample_processor.sv -----
// Guitar effect sample processor (clean, top-only distortion, fuzz, bit crusher). Takes one
// left-adjusted ADC word per transaction with the select/up/down button levels, and returns
// one result per sample: the two PWM bytes and the effect in use. One sample is accepted
// every clock cycle unless both registers hold data and the result is not taken; a result
// passes the input register, then the result register. The input register gives one sample of
// slack, so a new sample is still taken while a finished result waits downstream. Button
// polling, threshold saturation and effect processing are all done in the single stage between
// the two registers. Configuration writes take effect at once and belong to idle periods.
module guitar_effect_sample_processor #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_CRUSH    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gesp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gesp_pkg::CFG_W-1:0]      i_cfg_data,
    gesp_in_if.sink                         i_smp,
    gesp_out_if.source                      o_res
);
    import gesp_pkg::*;

    localparam int XW = (SAMPLE_WIDTH > ADC_W) ? SAMPLE_WIDTH : ADC_W;
    localparam int CW = XW + 1;
    localparam logic [CRUSH_W-1:0] CRUSH_MAX = CRUSH_W'(MAX_CRUSH);
    localparam logic [CRUSH_W:0]   CRUSH_ALL = (CRUSH_W + 1)'(SAMPLE_WIDTH);
    localparam logic [SAMPLE_WIDTH-1:0] SSIGN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [SAMPLE_WIDTH-1:0] SMAXV = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    // configuration
    logic [PERIOD_W-1:0] r_poll_period;
    logic [STEP_W-1:0]   r_step;
    logic [LEVEL_W-1:0]  r_def_clip;
    logic [LEVEL_W-1:0]  r_def_fuzz;

    // effect state
    t_effect             r_effect, n_effect;
    logic [PERIOD_W-1:0] r_poll_cnt, n_poll_cnt;
    logic [LEVEL_W-1:0]  r_clip, n_clip;
    logic [LEVEL_W-1:0]  r_fuzz, n_fuzz;
    logic [CRUSH_W-1:0]  r_crush, n_crush;

    // input register
    logic                    r_in_vld;
    logic [SAMPLE_WIDTH-1:0] r_smp;
    logic                    r_sel, r_up, r_down;

    // result register
    logic       r_out_vld;
    logic [7:0] r_hi, n_hi;
    logic [7:0] r_lo, n_lo;
    t_effect    r_out_eff;

    logic                    adv;
    logic [XW-1:0]           adc_x;
    logic [PERIOD_W-1:0]     cnt_inc;
    logic                    poll;
    logic [SAMPLE_WIDTH-1:0] u;
    logic [SAMPLE_WIDTH-1:0] ob;
    logic signed [CW-1:0]    s_x, clip_x, fuzz_x, nfuzz_x;
    logic [XW-1:0]           clip_w;

    function automatic logic [LEVEL_W-1:0] level_up(input logic [LEVEL_W-1:0] v,
                                                    input logic [STEP_W-1:0] st);
        logic [LEVEL_W:0] sum;
        sum = {1'b0, v} + {{(LEVEL_W + 1 - STEP_W){1'b0}}, st};
        return (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[LEVEL_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] level_down(input logic [LEVEL_W-1:0] v,
                                                      input logic [STEP_W-1:0] st);
        logic [LEVEL_W-1:0] st_x;
        st_x = {{(LEVEL_W - STEP_W){1'b0}}, st};
        return (v > st_x) ? v - st_x : '0;
    endfunction

    assign adv         = r_in_vld && (!r_out_vld || o_res.ready);
    // no transaction is taken while reset is held
    assign i_smp.ready = i_rst_n && (!r_in_vld || adv);
    assign adc_x       = XW'(i_smp.adc_word);

    // button polling and setting updates
    always_comb begin
        n_effect = r_effect;
        n_clip   = r_clip;
        n_fuzz   = r_fuzz;
        n_crush  = r_crush;
        if (r_sel) begin
            n_effect = t_effect'(r_effect + 2'd1);
        end
        cnt_inc    = r_poll_cnt + 8'd1;
        poll       = (cnt_inc == r_poll_period);
        n_poll_cnt = poll ? '0 : cnt_inc;
        if (poll) begin
            if (r_up && r_down) begin
                // restore defaults, then the decrease still applies
                n_effect = EFF_CLEAN;
                n_clip   = level_down(r_def_clip, r_step);
                n_fuzz   = level_down(r_def_fuzz, r_step);
                n_crush  = '0;
            end else if (r_up) begin
                n_clip  = level_up(r_clip, r_step);
                n_fuzz  = level_up(r_fuzz, r_step);
                n_crush = (r_crush < CRUSH_MAX) ? r_crush + 5'd1 : r_crush;
            end else if (r_down) begin
                n_clip  = level_down(r_clip, r_step);
                n_fuzz  = level_down(r_fuzz, r_step);
                n_crush = (r_crush != '0) ? r_crush - 5'd1 : r_crush;
            end
        end
    end

    // sample processing with the updated settings
    always_comb begin
        s_x     = {{(CW - SAMPLE_WIDTH){r_smp[SAMPLE_WIDTH-1]}}, r_smp};
        clip_x  = {{(CW - LEVEL_W){1'b0}}, n_clip};
        fuzz_x  = {{(CW - LEVEL_W){1'b0}}, n_fuzz};
        nfuzz_x = -fuzz_x;
        clip_w  = {{(XW - LEVEL_W){1'b0}}, n_clip};
        u       = r_smp;
        case (n_effect)
            EFF_CLEAN: begin
                u = r_smp;
            end
            EFF_DIST: begin
                if (s_x > clip_x) begin
                    u = clip_w[SAMPLE_WIDTH-1:0];
                end
            end
            EFF_FUZZ: begin
                if (s_x > fuzz_x) begin
                    u = SMAXV;
                end else if (s_x < nfuzz_x) begin
                    u = SSIGN;
                end
            end
            EFF_CRUSH: begin
                if ({1'b0, n_crush} >= CRUSH_ALL) begin
                    u = '0;
                end else begin
                    for (int i = 0; i < SAMPLE_WIDTH; i++) begin
                        if (CRUSH_W'(i) < n_crush) begin
                            u[i] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                u = r_smp;
            end
        endcase
        ob   = u ^ SSIGN;
        n_hi = ob[SAMPLE_WIDTH-1 -: 8];
        n_lo = u[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_period <= RST_POLL_PERIOD;
            r_step        <= RST_STEP;
            r_def_clip    <= RST_CLIP_LEVEL;
            r_def_fuzz    <= RST_FUZZ_LEVEL;
            r_effect      <= EFF_CLEAN;
            r_poll_cnt    <= '0;
            r_clip        <= RST_CLIP_LEVEL;
            r_fuzz        <= RST_FUZZ_LEVEL;
            r_crush       <= '0;
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_POLL_PERIOD:  r_poll_period <= i_cfg_data[PERIOD_W-1:0];
                    CFG_THRESH_STEP:  r_step        <= i_cfg_data[STEP_W-1:0];
                    CFG_DEFAULT_CLIP: r_def_clip    <= i_cfg_data[LEVEL_W-1:0];
                    CFG_DEFAULT_FUZZ: r_def_fuzz    <= i_cfg_data[LEVEL_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_smp.ready) begin
                r_in_vld <= i_smp.valid;
            end
            if (adv) begin
                r_effect   <= n_effect;
                r_poll_cnt <= n_poll_cnt;
                r_clip     <= n_clip;
                r_fuzz     <= n_fuzz;
                r_crush    <= n_crush;
                r_out_vld  <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_smp  <= adc_x[SAMPLE_WIDTH-1:0] ^ SSIGN;
            r_sel  <= i_smp.select_button;
            r_up   <= i_smp.up_button;
            r_down <= i_smp.down_button;
        end
        if (adv) begin
            r_hi      <= n_hi;
            r_lo      <= n_lo;
            r_out_eff <= n_effect;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.pwm_high_byte = r_hi;
    assign o_res.pwm_low_byte  = r_lo;
    assign o_res.active_effect = r_out_eff;

`ifndef ASSERT_OFF
    a_crush_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_crush <= CRUSH_MAX)
        else $error("crush amount above its maximum");

    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !o_res.ready) |-> !i_smp.ready)
        else $error("input taken while both stages are full");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && (!r_out_vld || o_res.ready)) |=> o_res.valid)
        else $error("pending sample did not produce a result");

    a_poll_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && poll) |=> (r_poll_cnt == '0))
        else $error("poll counter not cleared at poll");
`endif

endmodule
